### design/lssw_pkg.sv
// ----------------------------------------------------------------------------
// lssw_pkg
// Shared types and constants for the segment LCD serial writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lssw_pkg;

    // Operation codes carried on s_tuser.
    localparam logic [1:0] OP_CMD    = 2'd0;
    localparam logic [1:0] OP_NIBBLE = 2'd1;
    localparam logic [1:0] OP_GLYPH  = 2'd2;

    // Frame mode prefixes, sent first.
    localparam logic [2:0] MODE_CMD  = 3'b100;
    localparam logic [2:0] MODE_DATA = 3'b101;

    localparam logic [3:0] DP_BIT   = 4'b1000;
    localparam logic [3:0] NIB_MASK = 4'b1111;

    // Bits left to shift after the first bit of a frame.
    localparam logic [3:0] CMD_REST  = 4'd11;
    localparam logic [3:0] DATA_REST = 4'd12;

    // Display address of each nibble, indexed by {digit, nibble number}.
    localparam logic [4:0] DIGIT_ADDR_TABLE [32] = '{
        5'd1,  5'd31, 5'd30, 5'd0,
        5'd3,  5'd29, 5'd27, 5'd2,
        5'd5,  5'd28, 5'd26, 5'd4,
        5'd7,  5'd25, 5'd24, 5'd6,
        5'd9,  5'd23, 5'd22, 5'd8,
        5'd11, 5'd21, 5'd20, 5'd10,
        5'd13, 5'd19, 5'd18, 5'd12,
        5'd15, 5'd17, 5'd16, 5'd14
    };

    // One frame request between the front end and the serializer.
    typedef struct packed {
        logic       is_cmd;
        logic [4:0] addr;
        logic [7:0] data;       // command byte, or nibble in the low bits
        logic       item_end;
    } frame_t;

endpackage

`default_nettype wire

### design/lssw_ram.sv
// ----------------------------------------------------------------------------
// lssw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lssw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/lssw_front.sv
// ----------------------------------------------------------------------------
// lssw_front
// Accepts items, splits glyphs into nibbles, checks the shadow store and
// hands the frames that must be sent to the queue, marking the item's last.
// ----------------------------------------------------------------------------
`default_nettype none

module lssw_front
    import lssw_pkg::*;
#(
    parameter int SHADOW_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_op,
    input  wire logic [7:0]  in_cmd,
    input  wire logic [4:0]  in_addr,
    input  wire logic [3:0]  in_nib,
    input  wire logic [15:0] in_pat,
    input  wire logic        in_dp,
    input  wire logic [2:0]  in_digit,
    input  wire logic        q_full,
    output logic             q_push,
    output frame_t           q_frame
);

    localparam int         IDX_W  = $clog2(SHADOW_DEPTH);
    localparam logic [6:0] DEPTH7 = 7'(SHADOW_DEPTH);

    function automatic logic [IDX_W-1:0] shadow_index(input logic [4:0] a);
        logic [6:0] w;
        begin
            w = {2'b00, a};
            if (w >= DEPTH7) begin
                w = w - DEPTH7;
            end
            return w[IDX_W-1:0];
        end
    endfunction

    // Item register (stage A).
    logic        it_valid_reg, it_valid_next;
    logic [1:0]  it_op_reg;
    logic [7:0]  it_cmd_reg;
    logic [4:0]  it_addr_reg;
    logic [3:0]  it_nib_reg;
    logic [15:0] it_pat_reg;
    logic        it_dp_reg;
    logic [2:0]  it_digit_reg;
    logic [1:0]  k_reg, k_next;

    // Compare stage (stage B).
    logic             b_valid_reg, b_valid_next;
    logic             b_is_cmd_reg;
    logic [4:0]       b_addr_reg;
    logic [3:0]       b_nib_reg;
    logic [7:0]       b_cmd_reg;
    logic             b_last_reg;
    logic [IDX_W-1:0] b_idx_reg;
    logic             b_fwd_hit_reg;
    logic [3:0]       b_fwd_data_reg;
    logic             b_vld_reg;

    // Held frame, so that the last sent frame of an item can be marked.
    logic   pend_valid_reg, pend_valid_next;
    logic   pend_final_reg, pend_final_next;
    frame_t pend_frame_reg, pend_frame_next;

    logic [SHADOW_DEPTH-1:0] valid_reg;

    logic             cur_is_cmd;
    logic [4:0]       cur_addr;
    logic [3:0]       cur_nib;
    logic             cur_last;
    logic [IDX_W-1:0] cur_idx;
    logic             a_fire;
    logic             accept;
    logic [3:0]       ram_rdata;
    logic [3:0]       b_old;
    logic             b_differs;
    logic             b_emit;
    logic             b_fire;
    logic             b_write;
    frame_t           b_frame;

    always_comb begin
        cur_is_cmd = (it_op_reg == OP_CMD);
        cur_addr   = '0;
        cur_nib    = '0;
        cur_last   = 1'b1;
        case (it_op_reg)
            OP_NIBBLE: begin
                cur_addr = it_addr_reg;
                cur_nib  = it_nib_reg;
            end
            OP_GLYPH: begin
                cur_addr = DIGIT_ADDR_TABLE[{it_digit_reg, k_reg}];
                cur_last = (k_reg == 2'd3);
                case (k_reg)
                    2'd0:    cur_nib = (it_pat_reg[15:12] | (it_dp_reg ? DP_BIT : 4'd0))
                                       & NIB_MASK;
                    2'd1:    cur_nib = it_pat_reg[11:8];
                    2'd2:    cur_nib = it_pat_reg[7:4];
                    default: cur_nib = it_pat_reg[3:0];
                endcase
            end
            default: begin
                cur_addr = '0;
            end
        endcase
    end

    assign cur_idx = shadow_index(cur_addr);

    // Stage B resolves whether its frame must go out.
    assign b_old     = b_fwd_hit_reg ? b_fwd_data_reg : (b_vld_reg ? ram_rdata : 4'd0);
    assign b_differs = (b_old != b_nib_reg);
    assign b_emit    = b_is_cmd_reg || b_differs;
    assign b_fire    = b_valid_reg && (!b_emit || !pend_valid_reg || !q_full);
    assign b_write   = b_fire && !b_is_cmd_reg && b_differs;

    assign a_fire   = it_valid_reg && (!b_valid_reg || b_fire);
    assign in_ready = !it_valid_reg || (a_fire && cur_last);
    assign accept   = in_valid && in_ready;

    assign q_push = pend_valid_reg && !q_full && (pend_final_reg || (b_valid_reg && b_emit));

    always_comb begin
        q_frame          = pend_frame_reg;
        q_frame.item_end = pend_final_reg;
    end

    always_comb begin
        b_frame.is_cmd   = b_is_cmd_reg;
        b_frame.addr     = b_addr_reg;
        b_frame.data     = b_is_cmd_reg ? b_cmd_reg : {4'd0, b_nib_reg};
        b_frame.item_end = 1'b0;
    end

    always_comb begin
        it_valid_next = it_valid_reg;
        k_next        = k_reg;
        if (accept) begin
            // The unused operation code is taken and dropped.
            it_valid_next = (in_op == OP_CMD) || (in_op == OP_NIBBLE) || (in_op == OP_GLYPH);
            k_next        = '0;
        end else if (a_fire) begin
            if (cur_last) begin
                it_valid_next = 1'b0;
            end else begin
                k_next = k_reg + 2'd1;
            end
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (a_fire) begin
            b_valid_next = 1'b1;
        end else if (b_fire) begin
            b_valid_next = 1'b0;
        end
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_final_next = pend_final_reg;
        pend_frame_next = pend_frame_reg;
        if (b_fire && b_emit) begin
            pend_valid_next = 1'b1;
            pend_final_next = b_last_reg;
            pend_frame_next = b_frame;
        end else if (q_push) begin
            pend_valid_next = 1'b0;
        end else if (b_fire && b_last_reg && pend_valid_reg) begin
            // Remaining nibbles were suppressed: the held frame ends the item.
            pend_final_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_valid_reg   <= 1'b0;
            k_reg          <= '0;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
            valid_reg      <= '0;
        end else begin
            it_valid_reg   <= it_valid_next;
            k_reg          <= k_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_final_reg <= pend_final_next;
            if (b_write) begin
                valid_reg[b_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_frame_reg <= pend_frame_next;
        if (accept) begin
            it_op_reg    <= in_op;
            it_cmd_reg   <= in_cmd;
            it_addr_reg  <= in_addr;
            it_nib_reg   <= in_nib;
            it_pat_reg   <= in_pat;
            it_dp_reg    <= in_dp;
            it_digit_reg <= in_digit;
        end
        if (a_fire) begin
            b_is_cmd_reg   <= cur_is_cmd;
            b_addr_reg     <= cur_addr;
            b_nib_reg      <= cur_nib;
            b_cmd_reg      <= it_cmd_reg;
            b_last_reg     <= cur_last;
            b_idx_reg      <= cur_idx;
            // The RAM returns the old entry if it is written in the read cycle.
            b_fwd_hit_reg  <= b_write && (b_idx_reg == cur_idx);
            b_fwd_data_reg <= b_nib_reg;
            b_vld_reg      <= valid_reg[cur_idx];
        end
    end

    lssw_ram #(
        .WIDTH(4),
        .DEPTH(SHADOW_DEPTH)
    ) u_shadow (
        .aclk  (aclk),
        .we    (b_write),
        .waddr (b_idx_reg),
        .wdata (b_nib_reg),
        .re    (a_fire),
        .raddr (cur_idx),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### design/lssw_fifo.sv
// ----------------------------------------------------------------------------
// lssw_fifo
// Short frame queue between the front end and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module lssw_fifo
    import lssw_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire frame_t push_frame,
    input  wire logic   pop,
    output frame_t      head,
    output logic        full,
    output logic        empty
);

    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] count_reg, count_next;
    frame_t     slots [4];

    assign full  = (count_reg == 3'd4);
    assign empty = (count_reg == 3'd0);
    assign head  = slots[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 3'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

### design/lssw_back.sv
// ----------------------------------------------------------------------------
// lssw_back
// Serializer: shifts each queued frame out MSB first, one bit per result.
// ----------------------------------------------------------------------------
`default_nettype none

module lssw_back
    import lssw_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_empty,
    input  wire frame_t q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic        out_bit,
    output logic        out_frame_end,
    output logic        out_item_end
);

    logic        act_reg;
    logic [11:0] sh_reg;
    logic [3:0]  cnt_reg;
    logic        ie_reg;
    logic        ov_reg;
    logic        bit_reg;
    logic        fend_reg;
    logic        iend_reg;

    logic        load;
    logic [12:0] word;
    logic        shift_last;

    assign load       = !ov_reg || out_ready;
    assign q_pop      = load && !act_reg && !q_empty;
    assign shift_last = (cnt_reg == 4'd1);

    always_comb begin
        if (q_head.is_cmd) begin
            word = {MODE_CMD, q_head.data, 2'b00};
        end else begin
            word = {MODE_DATA, 1'b0, q_head.addr, q_head.data[3:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else if (load) begin
            if (act_reg) begin
                ov_reg  <= 1'b1;
                act_reg <= !shift_last;
            end else begin
                ov_reg  <= !q_empty;
                act_reg <= !q_empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (act_reg) begin
                bit_reg  <= sh_reg[11];
                fend_reg <= shift_last;
                iend_reg <= shift_last && ie_reg;
                sh_reg   <= {sh_reg[10:0], 1'b0};
                cnt_reg  <= cnt_reg - 4'd1;
            end else begin
                // First bit goes straight from the queue head.
                bit_reg  <= word[12];
                fend_reg <= 1'b0;
                iend_reg <= 1'b0;
                sh_reg   <= word[11:0];
                cnt_reg  <= q_head.is_cmd ? CMD_REST : DATA_REST;
                ie_reg   <= q_head.item_end;
            end
        end
    end

    assign out_valid     = ov_reg;
    assign out_bit       = bit_reg;
    assign out_frame_end = fend_reg;
    assign out_item_end  = iend_reg;

endmodule

`default_nettype wire

### design/lcd_segment_serial_writer_unit.sv
// The first bit of an item's first sent frame passes the item register, the compare stage,
// the held frame, the queue and the serializer's output register. Throughput: one serial
// bit per cycle while the receiver is ready; a command frame holds 12 bits, a data frame 13,
// and a glyph up to four data frames. A suppressed nibble sends no serial bits.
// Reset clears all control state and the shadow valid bits, so every shadow entry reads
// as zero right away; there is no clearing pass.
// ----------------------------------------------------------------------------
// lcd_segment_serial_writer_unit
// Serializes command, nibble and glyph writes for a three-wire segment LCD
// controller, skipping data frames the display already holds.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_segment_serial_writer_unit
    import lssw_pkg::*;
#(
    parameter int SHADOW_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command_code[7:0], write_address[12:8], nibble_value[16:13],
    // segment_pattern[32:17], decimal_point[33], digit_position[36:34]
    input  wire logic [39:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // serial_bit[0]
    output logic [7:0]       m_tdata,
    // frame_end
    output logic             m_tlast,
    // item_end[0]
    output logic             m_tuser
);

    logic   q_push;
    frame_t q_in;
    logic   q_pop;
    frame_t q_head;
    logic   q_full;
    logic   q_empty;
    logic   serial_bit;

    lssw_front #(
        .SHADOW_DEPTH(SHADOW_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_cmd   (s_tdata[7:0]),
        .in_addr  (s_tdata[12:8]),
        .in_nib   (s_tdata[16:13]),
        .in_pat   (s_tdata[32:17]),
        .in_dp    (s_tdata[33]),
        .in_digit (s_tdata[36:34]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_frame  (q_in)
    );

    lssw_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_frame (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    lssw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_bit       (serial_bit),
        .out_frame_end (m_tlast),
        .out_item_end  (m_tuser)
    );

    assign m_tdata = {7'd0, serial_bit};

endmodule

`default_nettype wire

### design/lssw_checker.sv
// ----------------------------------------------------------------------------
// lssw_checker
// Port-level checks on the serial writer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lssw_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // A result that is not taken stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // The last bit of an item always closes a frame.
    a_item_end_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("item end without frame end");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Only the serial bit is carried; the padding stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("nonzero padding in result data");

endmodule

bind lcd_segment_serial_writer_unit lssw_checker u_lssw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/lssw_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lssw_scoreboard_pkg
// Predicts the serial bit stream of the segment LCD writer from accepted
// requests and checks each bit that leaves the block against it.
// ----------------------------------------------------------------------------

package lssw_scoreboard_pkg;

    import lssw_pkg::*;

    // The one operation code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic serial_bit;
        logic frame_end;
        logic item_end;
    } strobe_t;

    class lcd_frame_scoreboard;

        logic [3:0] display_copy [32];
        strobe_t    pending_bits [$];
        int         error_count;
        int         checked_bits;

        function new();
            foreach (display_copy[i]) display_copy[i] = 4'd0;
            error_count  = 0;
            checked_bits = 0;
        endfunction

        task report(string msg);
            if (error_count < 50) $display("MISMATCH: %s", msg);
            error_count++;
        endtask

        function void push_bits(logic [7:0] value, int nbits);
            for (int i = nbits - 1; i >= 0; i--) begin
                pending_bits.push_back(strobe_t'{value[i], 1'b0, 1'b0});
            end
        endfunction

        function void flag_last_bit(logic frame_end, logic item_end);
            strobe_t last;
            last = pending_bits.pop_back();
            last.frame_end = last.frame_end | frame_end;
            last.item_end  = last.item_end | item_end;
            pending_bits.push_back(last);
        endfunction

        // With 32 shadow entries the 5-bit address indexes the copy directly.
        function void queue_data_frame(logic [4:0] addr, logic [3:0] nibble);
            if (display_copy[addr] == nibble) return;
            push_bits({5'd0, MODE_DATA}, 3);
            push_bits({3'd0, addr}, 6);
            push_bits({4'd0, nibble}, 4);
            flag_last_bit(1'b1, 1'b0);
            display_copy[addr] = nibble;
        endfunction

        function void note_request(logic [1:0] op, logic [39:0] data);
            int          queued;
            logic [15:0] pattern;
            logic [2:0]  digit;
            logic [3:0]  lead;
            queued = pending_bits.size();
            case (op)
                OP_CMD: begin
                    push_bits({5'd0, MODE_CMD}, 3);
                    push_bits(data[7:0], 8);
                    push_bits(8'd0, 1);
                    flag_last_bit(1'b1, 1'b0);
                end
                OP_NIBBLE: begin
                    queue_data_frame(data[12:8], data[16:13]);
                end
                OP_GLYPH: begin
                    pattern = data[32:17];
                    digit   = data[36:34];
                    lead    = pattern[15:12] | (data[33] ? DP_BIT : 4'd0);
                    queue_data_frame(DIGIT_ADDR_TABLE[{digit, 2'd0}], lead);
                    queue_data_frame(DIGIT_ADDR_TABLE[{digit, 2'd1}], pattern[11:8]);
                    queue_data_frame(DIGIT_ADDR_TABLE[{digit, 2'd2}], pattern[7:4]);
                    queue_data_frame(DIGIT_ADDR_TABLE[{digit, 2'd3}], pattern[3:0]);
                end
                default: ;
            endcase
            if (pending_bits.size() > queued) flag_last_bit(1'b0, 1'b1);
        endfunction

        task check_result(logic [7:0] tdata, logic tlast, logic tuser);
            strobe_t want;
            checked_bits++;
            if (pending_bits.size() == 0) begin
                report($sformatf("bit %0d arrived with nothing expected", checked_bits));
                return;
            end
            want = pending_bits.pop_front();
            if (tdata !== {7'd0, want.serial_bit})
                report($sformatf("bit %0d: data %h, expected %h", checked_bits, tdata,
                                 {7'd0, want.serial_bit}));
            if (tlast !== want.frame_end)
                report($sformatf("bit %0d: frame end %b, expected %b", checked_bits, tlast,
                                 want.frame_end));
            if (tuser !== want.item_end)
                report($sformatf("bit %0d: item end %b, expected %b", checked_bits, tuser,
                                 want.item_end));
        endtask

        task check_drained();
            if (pending_bits.size() != 0)
                report($sformatf("%0d expected bits never arrived", pending_bits.size()));
        endtask

    endclass

endpackage

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command, nibble and glyph requests into the segment LCD writer with
// bursty input and a stalling receiver, and checks every serial bit.
// ----------------------------------------------------------------------------

module tb;

    import lssw_pkg::*;
    import lssw_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    lcd_frame_scoreboard board = new();

    bit hold_off_armed = 1'b0;
    int burst_left     = 1;

    lcd_segment_serial_writer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [39:0] pack_request(logic [7:0] cmd, logic [4:0] addr,
                                                 logic [3:0] nibble, logic [15:0] pattern,
                                                 logic dp, logic [2:0] digit);
        return {3'd0, digit, dp, pattern, nibble, addr, cmd};
    endfunction

    function automatic logic [39:0] random_request();
        return pack_request(8'($urandom), 5'($urandom), 4'($urandom), 16'($urandom),
                            1'($urandom), 3'($urandom));
    endfunction

    // The helpers below fix the fields an operation uses and leave the rest random.
    function automatic logic [39:0] cmd_request(logic [7:0] cmd);
        logic [39:0] r;
        r      = random_request();
        r[7:0] = cmd;
        return r;
    endfunction

    function automatic logic [39:0] nibble_request(logic [4:0] addr, logic [3:0] nibble);
        logic [39:0] r;
        r        = random_request();
        r[12:8]  = addr;
        r[16:13] = nibble;
        return r;
    endfunction

    function automatic logic [39:0] glyph_request(logic [15:0] pattern, logic dp,
                                                  logic [2:0] digit);
        logic [39:0] r;
        r        = random_request();
        r[32:17] = pattern;
        r[33]    = dp;
        r[36:34] = digit;
        return r;
    endfunction

    // Holds the request until it is taken, then idles the input now and then.
    task automatic send_request(logic [1:0] op, logic [39:0] data);
        int gap;
        s_tuser  <= op;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_request(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast, m_tuser);
    end

    // Receiver: stretches of free flow and of varying stall density, plus one long hold.
    initial begin : receiver
        int mode;
        int stretch;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            for (int k = 0; k < stretch; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge aclk);
            end
            if (hold_off_armed) begin
                hold_off_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int          counted;
        int          pick;
        logic [1:0]  op;
        logic [39:0] data;
        logic [39:0] last_nibble_req;
        logic [39:0] last_glyph_req;
        bit          have_nibble;
        bit          have_glyph;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_CMD;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Command extremes.
        send_request(OP_CMD, cmd_request(8'h00));
        send_request(OP_CMD, cmd_request(8'hFF));
        send_request(OP_CMD, cmd_request(8'hA5));
        // Nibble writes: the first matches the cleared shadow and sends nothing.
        send_request(OP_NIBBLE, nibble_request(5'd0, 4'h0));
        send_request(OP_NIBBLE, nibble_request(5'd31, 4'hF));
        send_request(OP_NIBBLE, nibble_request(5'd31, 4'hF));
        send_request(OP_NIBBLE, nibble_request(5'd0, 4'hF));
        send_request(OP_NIBBLE, nibble_request(5'd16, 4'h1));
        send_request(OP_UNUSED, random_request());
        // Glyphs: full send, full suppression, the decimal point merging into
        // the lead nibble, and partial suppression.
        send_request(OP_GLYPH, glyph_request(16'hFFFF, 1'b1, 3'd0));
        send_request(OP_GLYPH, glyph_request(16'hFFFF, 1'b1, 3'd0));
        send_request(OP_GLYPH, glyph_request(16'h7FFF, 1'b1, 3'd0));
        send_request(OP_GLYPH, glyph_request(16'h0000, 1'b0, 3'd7));
        send_request(OP_GLYPH, glyph_request(16'hFFFF, 1'b0, 3'd7));
        send_request(OP_GLYPH, glyph_request(16'h1234, 1'b0, 3'd3));
        send_request(OP_GLYPH, glyph_request(16'h1234, 1'b1, 3'd3));
        send_request(OP_GLYPH, glyph_request(16'h0000, 1'b1, 3'd5));
        send_request(OP_NIBBLE, nibble_request(5'd15, 4'h0));
        send_request(OP_CMD, cmd_request(8'h5A));
        send_request(OP_GLYPH, glyph_request(16'h0000, 1'b0, 3'd0));

        hold_off_armed = 1'b1;
        counted     = 0;
        have_nibble = 1'b0;
        have_glyph  = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       op = OP_UNUSED;
            else if (pick < 25) op = OP_CMD;
            else if (pick < 60) op = OP_NIBBLE;
            else                op = OP_GLYPH;
            data = random_request();
            // Repeating a recent write makes suppression common.
            if (op == OP_NIBBLE) begin
                if (have_nibble && $urandom_range(0, 3) == 0) data = last_nibble_req;
                last_nibble_req = data;
                have_nibble     = 1'b1;
            end else if (op == OP_GLYPH) begin
                if (have_glyph && $urandom_range(0, 4) == 0) data = last_glyph_req;
                last_glyph_req = data;
                have_glyph     = 1'b1;
            end
            send_request(op, data);
            if (op != OP_UNUSED) counted++;
        end
        s_tvalid <= 1'b0;

        while (board.pending_bits.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        board.check_drained();
        if (board.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
design/lssw_pkg.sv
design/lssw_ram.sv
design/lssw_front.sv
design/lssw_fifo.sv
design/lssw_back.sv
design/lcd_segment_serial_writer_unit.sv
design/lssw_checker.sv
verif/lssw_scoreboard_pkg.sv
verif/tb.sv
